[hdl/irs_pkg.sv]
// Package of the image resize sampler: field widths, register map, codes and
// the geometry bundle shared by the sampler modules. No dependencies.
package irs_pkg;

    // Default store geometry.
    localparam int IRS_MAX_WIDTH  = 128;
    localparam int IRS_MAX_HEIGHT = 128;
    localparam int IRS_CHANNELS   = 3;

    // Item and result fields.
    localparam int COL_BITS   = 7;
    localparam int ROW_BITS   = 7;
    localparam int CH_BITS    = 2;
    localparam int PIX_BITS   = 8;
    localparam int SIZE_BITS  = 8;
    localparam int SCALE_BITS = 24;

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Fixed-point widths: Q16 fractions, Q32 weights, Q32 accumulator.
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 32;
    localparam int WGT_BITS  = 33;
    localparam int ACC_BITS  = 40;
    localparam int COORD_BITS = 16;

    // Register indexes (byte address bits [4:2]).
    localparam logic [2:0] REG_SOURCE_WIDTH     = 3'd0;
    localparam logic [2:0] REG_SOURCE_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_HORIZONTAL_SCALE = 3'd2;
    localparam logic [2:0] REG_VERTICAL_SCALE   = 3'd3;
    localparam logic [2:0] REG_SAMPLING_MODE    = 3'd4;

    // Register reset values.
    localparam logic [SIZE_BITS-1:0]  RST_SOURCE_WIDTH  = 8'd128;
    localparam logic [SIZE_BITS-1:0]  RST_SOURCE_HEIGHT = 8'd128;
    localparam logic [SCALE_BITS-1:0] RST_SCALE         = 24'h010000;

    // Item kinds and sampling modes.
    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;
    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;
    localparam logic RST_SAMPLING_MODE = MODE_BILINEAR;

    typedef struct packed {
        logic [SCALE_BITS-1:0] hscale;
        logic [SCALE_BITS-1:0] vscale;
        logic                  mode;
    } irs_geom_t;

endpackage

[hdl/irs_if.sv]
// Handshake interfaces of the image resize sampler: the item channel and the
// result channel. Depends on irs_pkg for the field widths.
interface irs_item_if;
    import irs_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [COL_BITS-1:0] column;
    logic [ROW_BITS-1:0] row;
    logic [CH_BITS-1:0]  channel_index;
    logic [PIX_BITS-1:0] pixel_value;

    modport source (output valid, kind, column, row, channel_index, pixel_value,
                    input ready);
    modport sink   (input valid, kind, column, row, channel_index, pixel_value,
                    output ready);
endinterface

interface irs_result_if;
    import irs_pkg::*;

    logic                valid;
    logic                ready;
    logic [PIX_BITS-1:0] sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

[hdl/image_resize_sampler.sv]
// Image resize sampler: a pixel write leaves the item channel ready. A request's result is
// built from four reads (one in nearest mode, none for a bad channel) of the single-read-port
// pixel memory behind a three-stage coordinate pipeline. The item channel is ready again in
// the cycle the result appears, so a request is accepted only once the previous one's result
// appears, and later still while an earlier result is not taken.
// rst_n clears the control state and loads the register reset values; memory is not cleared.
module image_resize_sampler #(
    parameter int MAX_WIDTH  = irs_pkg::IRS_MAX_WIDTH,
    parameter int MAX_HEIGHT = irs_pkg::IRS_MAX_HEIGHT,
    parameter int CHANNELS   = irs_pkg::IRS_CHANNELS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [irs_pkg::PADDR_W-1:0]  paddr,
    input  logic [irs_pkg::PDATA_W-1:0]  pwdata,
    output logic [irs_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    irs_item_if.sink                     item,
    irs_result_if.source                 result
);
    import irs_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (2 * FRAC_BITS - 1);

    typedef enum logic [2:0] {ST_IDLE, ST_GEO, ST_FETCH, ST_DRAIN, ST_FINISH} state_t;

    // Configuration registers.
    logic [SIZE_BITS-1:0]  source_width_reg, source_height_reg;
    logic [SCALE_BITS-1:0] horizontal_scale_reg, vertical_scale_reg;
    logic                  sampling_mode_reg;
    logic                  cfg_wr;

    state_t               state_reg, state_next;
    logic                 res_valid_reg, res_valid_next;
    logic [PIX_BITS-1:0]  sample_reg, sample_next;
    logic                 pend_reg, pend_next;
    logic [1:0]           cnt_reg, cnt_next, pidx_reg, pidx_next;
    logic [ACC_BITS-1:0]  acc_reg, acc_next;

    logic                 accept, is_write, is_req, ch_ok, wr_in_range;
    logic [CW-1:0]        width_last;
    logic [RW-1:0]        height_last;
    logic [1:0]           fetch_last;
    irs_geom_t            geom;
    logic                 coord_done;
    logic [AW-1:0]        rd_addr [4];
    logic [WGT_BITS-1:0]  weight [4];
    logic                 rd_en;
    logic [PIX_BITS-1:0]  rd_data;
    logic [AW-1:0]        wr_addr;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg     <= RST_SOURCE_WIDTH;
            source_height_reg    <= RST_SOURCE_HEIGHT;
            horizontal_scale_reg <= RST_SCALE;
            vertical_scale_reg   <= RST_SCALE;
            sampling_mode_reg    <= RST_SAMPLING_MODE;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_SOURCE_WIDTH:     source_width_reg     <= pwdata[SIZE_BITS-1:0];
                REG_SOURCE_HEIGHT:    source_height_reg    <= pwdata[SIZE_BITS-1:0];
                REG_HORIZONTAL_SCALE: horizontal_scale_reg <= pwdata[SCALE_BITS-1:0];
                REG_VERTICAL_SCALE:   vertical_scale_reg   <= pwdata[SCALE_BITS-1:0];
                REG_SAMPLING_MODE:    sampling_mode_reg    <= pwdata[0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_SOURCE_WIDTH:     prdata = PDATA_W'(source_width_reg);
            REG_SOURCE_HEIGHT:    prdata = PDATA_W'(source_height_reg);
            REG_HORIZONTAL_SCALE: prdata = PDATA_W'(horizontal_scale_reg);
            REG_VERTICAL_SCALE:   prdata = PDATA_W'(vertical_scale_reg);
            REG_SAMPLING_MODE:    prdata = PDATA_W'(sampling_mode_reg);
            default:              prdata = '0;
        endcase
    end

    // Last valid source column and row; a size of zero acts as one.
    always_comb
    begin
        if (source_width_reg == '0)
            width_last = '0;
        else if (32'(source_width_reg) > 32'(MAX_WIDTH))
            width_last = CW'(MAX_WIDTH - 1);
        else
            width_last = CW'(32'(source_width_reg) - 32'd1);

        if (source_height_reg == '0)
            height_last = '0;
        else if (32'(source_height_reg) > 32'(MAX_HEIGHT))
            height_last = RW'(MAX_HEIGHT - 1);
        else
            height_last = RW'(32'(source_height_reg) - 32'd1);
    end

    assign geom.hscale = horizontal_scale_reg;
    assign geom.vscale = vertical_scale_reg;
    assign geom.mode   = sampling_mode_reg;

    // Item decode.
    assign item.ready  = (state_reg == ST_IDLE);
    assign accept      = item.valid && item.ready;
    assign is_write    = accept && (item.kind == KIND_WRITE);
    assign is_req      = accept && (item.kind == KIND_REQUEST);
    assign ch_ok       = 32'(item.channel_index) < 32'(CHANNELS);
    assign wr_in_range = (32'(item.column) < 32'(MAX_WIDTH))
                      && (32'(item.row) < 32'(MAX_HEIGHT)) && ch_ok;
    assign wr_addr = AW'((32'(item.row) * 32'(MAX_WIDTH) + 32'(item.column))
                         * 32'(CHANNELS) + 32'(item.channel_index));

    irs_coord_unit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CHANNELS   (CHANNELS),
        .CW         (CW),
        .RW         (RW),
        .AW         (AW)
    ) u_coord (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (is_req && ch_ok),
        .column        (item.column),
        .row           (item.row),
        .channel_index (item.channel_index),
        .geom          (geom),
        .width_last    (width_last),
        .height_last   (height_last),
        .done          (coord_done),
        .rd_addr       (rd_addr),
        .weight        (weight)
    );

    irs_pixel_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (is_write && wr_in_range),
        .wr_addr (wr_addr),
        .wr_data (item.pixel_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr[cnt_reg]),
        .rd_data (rd_data)
    );

    assign fetch_last = (sampling_mode_reg == MODE_BILINEAR) ? 2'd3 : 2'd0;
    assign rd_en      = (state_reg == ST_FETCH);

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        sample_next    = sample_reg;
        cnt_next       = cnt_reg;
        pidx_next      = pidx_reg;
        pend_next      = 1'b0;
        acc_next       = acc_reg;

        if (result.valid && result.ready)
            res_valid_next = 1'b0;

        // Read data is registered in the store, so it arrives in the cycle after the address; fold it in then.
        if (pend_reg)
            acc_next = acc_reg + ACC_BITS'(weight[pidx_reg]) * ACC_BITS'(rd_data);

        case (state_reg)
            ST_IDLE:
            begin
                if (is_req)
                begin
                    acc_next   = ROUND_HALF;
                    state_next = ch_ok ? ST_GEO : ST_FINISH;
                end
            end
            ST_GEO:
            begin
                if (coord_done)
                begin
                    acc_next   = ROUND_HALF;
                    cnt_next   = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                pend_next = 1'b1;
                pidx_next = cnt_reg;
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg == fetch_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!result.valid || result.ready)
                begin
                    res_valid_next = 1'b1;
                    sample_next    = acc_reg[ACC_BITS-1:2*FRAC_BITS];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        cnt_reg    <= cnt_next;
        pidx_reg   <= pidx_next;
        acc_reg    <= acc_next;
    end

    assign result.valid  = res_valid_reg;
    assign result.sample = sample_reg;

endmodule

[hdl/irs_pixel_store.sv]
// Source pixel memory: one synchronous write port and one read port with a
// registered read data output. Depends on irs_pkg for the pixel width.
module irs_pixel_store #(
    parameter int DEPTH = irs_pkg::IRS_MAX_WIDTH * irs_pkg::IRS_MAX_HEIGHT
                          * irs_pkg::IRS_CHANNELS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [irs_pkg::PIX_BITS-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [irs_pkg::PIX_BITS-1:0] rd_data
);
    import irs_pkg::*;

    logic [PIX_BITS-1:0] mem [DEPTH];
    logic [PIX_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/irs_coord_unit.sv]
// Three-stage coordinate pipeline: source position, clamped neighbor
// coordinates and fractions, then blend weights and store addresses.
// Depends on irs_pkg.
module irs_coord_unit #(
    parameter int MAX_WIDTH  = irs_pkg::IRS_MAX_WIDTH,
    parameter int MAX_HEIGHT = irs_pkg::IRS_MAX_HEIGHT,
    parameter int CHANNELS   = irs_pkg::IRS_CHANNELS,
    parameter int CW = $clog2(MAX_WIDTH),
    parameter int RW = $clog2(MAX_HEIGHT),
    parameter int AW = $clog2(MAX_WIDTH * MAX_HEIGHT * CHANNELS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [irs_pkg::COL_BITS-1:0]  column,
    input  logic [irs_pkg::ROW_BITS-1:0]  row,
    input  logic [irs_pkg::CH_BITS-1:0]   channel_index,
    input  irs_pkg::irs_geom_t            geom,
    input  logic [CW-1:0]                 width_last,
    input  logic [RW-1:0]                 height_last,
    output logic                          done,
    output logic [AW-1:0]                 rd_addr [4],
    output logic [irs_pkg::WGT_BITS-1:0]  weight [4]
);
    import irs_pkg::*;

    localparam logic [FRAC_BITS:0] ONE_Q16  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PROD_BITS-1:0] HALF_Q16 = PROD_BITS'(1) << (FRAC_BITS - 1);

    logic s1_v_reg, s2_v_reg, s3_v_reg;

    // Stage 1: doubled position products.
    logic [PROD_BITS-1:0] prodx_reg, prody_reg;
    logic [CH_BITS-1:0]   ch1_reg, ch2_reg;
    logic                 mode1_reg;

    // Stage 2: clamped neighbor coordinates and fractions.
    logic [CW-1:0]        cx1_reg, cx2_reg;
    logic [RW-1:0]        cy1_reg, cy2_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;

    logic [PROD_BITS-1:0]  bx, by;
    logic [COORD_BITS-1:0] x1b, y1b, nx, ny;
    logic [CW-1:0]         cx1_next, cx2_next;
    logic [RW-1:0]         cy1_next, cy2_next;
    logic [FRAC_BITS-1:0]  fx_next, fy_next;

    // Stage 3 operands.
    logic [FRAC_BITS:0] gx, gy, fxe, fye;

    function automatic logic [CW-1:0] clamp_x(input logic [COORD_BITS-1:0] v,
                                              input logic [CW-1:0] last);
        logic [CW-1:0] r;
        if (v > COORD_BITS'(last))
            r = last;
        else
            r = CW'(v);
        return r;
    endfunction

    function automatic logic [RW-1:0] clamp_y(input logic [COORD_BITS-1:0] v,
                                              input logic [RW-1:0] last);
        logic [RW-1:0] r;
        if (v > COORD_BITS'(last))
            r = last;
        else
            r = RW'(v);
        return r;
    endfunction

    function automatic logic [AW-1:0] store_addr(input logic [CW-1:0] x,
                                                 input logic [RW-1:0] y,
                                                 input logic [CH_BITS-1:0] c);
        logic [31:0] lin;
        lin = (32'(y) * 32'(MAX_WIDTH) + 32'(x)) * 32'(CHANNELS) + 32'(c);
        return AW'(lin);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prodx_reg <= PROD_BITS'({column, 1'b1}) * PROD_BITS'(geom.hscale);
            prody_reg <= PROD_BITS'({row, 1'b1}) * PROD_BITS'(geom.vscale);
            ch1_reg   <= channel_index;
            mode1_reg <= geom.mode;
        end
    end

    // Position plus one in Q16 is half the product plus one half; its integer
    // part is the right-hand neighbor. Nearest rounding reduces to prod >> 17.
    always_comb
    begin
        bx = {1'b0, prodx_reg[PROD_BITS-1:1]} + HALF_Q16;
        by = {1'b0, prody_reg[PROD_BITS-1:1]} + HALF_Q16;
        x1b = bx[PROD_BITS-1:FRAC_BITS];
        y1b = by[PROD_BITS-1:FRAC_BITS];
        nx = COORD_BITS'(prodx_reg[PROD_BITS-1:FRAC_BITS+1]);
        ny = COORD_BITS'(prody_reg[PROD_BITS-1:FRAC_BITS+1]);
        if (mode1_reg == MODE_BILINEAR)
        begin
            cx1_next = (x1b == '0) ? '0 : clamp_x(x1b - COORD_BITS'(1), width_last);
            cx2_next = clamp_x(x1b, width_last);
            cy1_next = (y1b == '0) ? '0 : clamp_y(y1b - COORD_BITS'(1), height_last);
            cy2_next = clamp_y(y1b, height_last);
            fx_next  = bx[FRAC_BITS-1:0];
            fy_next  = by[FRAC_BITS-1:0];
        end
        else
        begin
            // Zero fractions put the whole weight on the first neighbor.
            cx1_next = clamp_x(nx, width_last);
            cx2_next = cx1_next;
            cy1_next = clamp_y(ny, height_last);
            cy2_next = cy1_next;
            fx_next  = '0;
            fy_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
        begin
            cx1_reg <= cx1_next;
            cx2_reg <= cx2_next;
            cy1_reg <= cy1_next;
            cy2_reg <= cy2_next;
            fx_reg  <= fx_next;
            fy_reg  <= fy_next;
            ch2_reg <= ch1_reg;
        end
    end

    assign fxe = {1'b0, fx_reg};
    assign fye = {1'b0, fy_reg};
    assign gx  = ONE_Q16 - fxe;
    assign gy  = ONE_Q16 - fye;

    always_ff @(posedge clk)
    begin
        if (s2_v_reg)
        begin
            weight[0]  <= WGT_BITS'(34'(gx) * 34'(gy));
            weight[1]  <= WGT_BITS'(34'(fxe) * 34'(gy));
            weight[2]  <= WGT_BITS'(34'(gx) * 34'(fye));
            weight[3]  <= WGT_BITS'(34'(fxe) * 34'(fye));
            rd_addr[0] <= store_addr(cx1_reg, cy1_reg, ch2_reg);
            rd_addr[1] <= store_addr(cx2_reg, cy1_reg, ch2_reg);
            rd_addr[2] <= store_addr(cx1_reg, cy2_reg, ch2_reg);
            rd_addr[3] <= store_addr(cx2_reg, cy2_reg, ch2_reg);
        end
    end

    assign done = s3_v_reg;

endmodule

[hdl/irs_checker.sv]
// Port-level checks of the image resize sampler and the bind that attaches
// them to the top level. Depends on irs_pkg and image_resize_sampler.
module irs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         in_kind,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [irs_pkg::PIX_BITS-1:0] sample
);
    import irs_pkg::*;

    // A sample request keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_kind == KIND_REQUEST) |=> !in_ready)
        else $error("request did not make the block busy");

    // A pixel write leaves the item channel ready in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_kind == KIND_WRITE) |=> in_ready)
        else $error("pixel write stalled the item channel");

    // A new result only appears at the end of a request's work.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while the block was idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample))
        else $error("stalled result changed or dropped");

endmodule

bind image_resize_sampler irs_checker u_irs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_kind   (item.kind),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sample    (result.sample)
);

[dv/tb.sv]
// Self-checking testbench of image_resize_sampler: a scoreboard keeps its own pixel store
// and register copy, predicts every requested sample and compares the results in order.
// Depends on irs_pkg, the handshake interfaces in irs_if and the sampler RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irs_pkg::*;

    localparam int STORE_DEPTH   = IRS_MAX_WIDTH * IRS_MAX_HEIGHT * IRS_CHANNELS;
    localparam int BAD_CHANNEL   = IRS_CHANNELS;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 42;
    localparam int HOLD_PHASE    = 3;
    localparam int STEADY_PHASE  = 5;
    localparam int LONG_HOLD     = 200;
    localparam int DRAIN_GAP     = 12;
    localparam int STALL_LIMIT   = 2000;

    typedef int unsigned tap_q_t[$];

    class resample_scoreboard;
        logic [PIX_BITS-1:0]   pixels  [STORE_DEPTH];
        bit                    written [STORE_DEPTH];
        logic [SIZE_BITS-1:0]  width_reg;
        logic [SIZE_BITS-1:0]  height_reg;
        logic [SCALE_BITS-1:0] hscale_reg;
        logic [SCALE_BITS-1:0] vscale_reg;
        logic                  mode_reg;
        logic [PIX_BITS-1:0]   pending_samples[$];
        int mismatches;
        int items;
        int writes;
        int requests;
        int bilinear;
        int nearest;
        int checked;

        function new();
            width_reg  = RST_SOURCE_WIDTH;
            height_reg = RST_SOURCE_HEIGHT;
            hscale_reg = RST_SCALE;
            vscale_reg = RST_SCALE;
            mode_reg   = RST_SAMPLING_MODE;
        endfunction

        function void set_register(logic [2:0] idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_SOURCE_WIDTH:     width_reg  = value[SIZE_BITS-1:0];
                REG_SOURCE_HEIGHT:    height_reg = value[SIZE_BITS-1:0];
                REG_HORIZONTAL_SCALE: hscale_reg = value[SCALE_BITS-1:0];
                REG_VERTICAL_SCALE:   vscale_reg = value[SCALE_BITS-1:0];
                REG_SAMPLING_MODE:    mode_reg   = value[0];
                default: ;
            endcase
        endfunction

        function logic [PDATA_W-1:0] register_value(logic [2:0] idx);
            case (idx)
                REG_SOURCE_WIDTH:     return PDATA_W'(width_reg);
                REG_SOURCE_HEIGHT:    return PDATA_W'(height_reg);
                REG_HORIZONTAL_SCALE: return PDATA_W'(hscale_reg);
                REG_VERTICAL_SCALE:   return PDATA_W'(vscale_reg);
                REG_SAMPLING_MODE:    return PDATA_W'(mode_reg);
                default:              return '0;
            endcase
        endfunction

        // Source position in signed Q16: half of (2d+1)*scale, less one half pixel.
        function longint position(int unsigned d, logic [SCALE_BITS-1:0] scale);
            longint twice;
            twice = (2 * longint'(d) + 1) * longint'(scale);
            return (twice >>> 1) - 32768;
        endfunction

        function longint nearest_coord(longint p);
            if (p >= 0)
                return (p + 32768) >>> 16;
            return -((-p + 32768) >>> 16);
        endfunction

        function longint active_size(logic [SIZE_BITS-1:0] v, int limit);
            if (v == 0)
                return 1;
            if (v > limit)
                return limit;
            return longint'(v);
        endfunction

        function int unsigned store_index(longint x, longint y, int unsigned ch);
            longint w;
            longint h;
            w = active_size(width_reg, IRS_MAX_WIDTH);
            h = active_size(height_reg, IRS_MAX_HEIGHT);
            if (x < 0)
                x = 0;
            else if (x > w - 1)
                x = w - 1;
            if (y < 0)
                y = 0;
            else if (y > h - 1)
                y = h - 1;
            return 32'((y * IRS_MAX_WIDTH + x) * IRS_CHANNELS + ch);
        endfunction

        // Store entries a request reads, in the order of the bilinear weights.
        function tap_q_t taps(int unsigned col, int unsigned row, int unsigned ch);
            tap_q_t t;
            longint px;
            longint py;
            longint x1;
            longint y1;
            if (ch >= IRS_CHANNELS)
                return t;
            px = position(col, hscale_reg);
            py = position(row, vscale_reg);
            if (mode_reg == MODE_NEAREST)
            begin
                t.push_back(store_index(nearest_coord(px), nearest_coord(py), ch));
            end
            else
            begin
                x1 = ((px + 65536) >>> 16) - 1;
                y1 = ((py + 65536) >>> 16) - 1;
                t.push_back(store_index(x1, y1, ch));
                t.push_back(store_index(x1 + 1, y1, ch));
                t.push_back(store_index(x1, y1 + 1, ch));
                t.push_back(store_index(x1 + 1, y1 + 1, ch));
            end
            return t;
        endfunction

        function logic [PIX_BITS-1:0] resample(int unsigned col, int unsigned row,
                                               int unsigned ch);
            tap_q_t t;
            longint px;
            longint py;
            longint unsigned fx;
            longint unsigned fy;
            longint unsigned gx;
            longint unsigned gy;
            longint unsigned acc;
            if (ch >= IRS_CHANNELS)
                return '0;
            t = taps(col, row, ch);
            if (mode_reg == MODE_NEAREST)
                return pixels[t[0]];
            px = position(col, hscale_reg);
            py = position(row, vscale_reg);
            fx = (px + 65536) & 65535;
            fy = (py + 65536) & 65535;
            gx = 65536 - fx;
            gy = 65536 - fy;
            acc = gx * gy * pixels[t[0]] + fx * gy * pixels[t[1]]
                + gx * fy * pixels[t[2]] + fx * fy * pixels[t[3]];
            acc = (acc + 64'h8000_0000) >> 32;
            if (acc > 255)
                acc = 255;
            return acc[PIX_BITS-1:0];
        endfunction

        function void note_item(logic kind, int unsigned col, int unsigned row,
                                int unsigned ch, int unsigned value);
            int unsigned idx;
            if (kind == KIND_WRITE)
            begin
                if (ch < IRS_CHANNELS)
                begin
                    idx = (row * IRS_MAX_WIDTH + col) * IRS_CHANNELS + ch;
                    pixels[idx]  = value[PIX_BITS-1:0];
                    written[idx] = 1'b1;
                    writes++;
                    items++;
                end
            end
            else
            begin
                requests++;
                items++;
                if (ch < IRS_CHANNELS)
                begin
                    if (mode_reg == MODE_NEAREST)
                        nearest++;
                    else
                        bilinear++;
                end
                pending_samples.push_back(resample(col, row, ch));
            end
        endfunction

        function void check_sample(logic [PIX_BITS-1:0] sample);
            logic [PIX_BITS-1:0] want;
            if (pending_samples.size() == 0)
            begin
                $error("sample: expected none, actual %0d", sample);
                mismatches++;
                return;
            end
            want = pending_samples.pop_front();
            checked++;
            if (sample !== want)
            begin
                $error("sample: expected %0d, actual %0d", want, sample);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    bit                   steady;
    bit                   hold_request;
    int                   settings;
    resample_scoreboard   sb = new();

    irs_item_if   item_ch ();
    irs_result_if result_ch ();

    image_resize_sampler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // psel is left high between transfers; the caller drops it after the last one.
    task automatic apb_transfer(input logic wr, input logic [2:0] idx,
                                input logic [PDATA_W-1:0] wdata,
                                output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata = prdata;
    endtask

    task automatic set_register(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] rd;
        apb_transfer(1'b1, idx, value, rd);
        sb.set_register(idx, value);
        apb_transfer(1'b0, idx, '0, rd);
        if (rd !== sb.register_value(idx))
        begin
            $error("prdata: expected %0h, actual %0h", sb.register_value(idx), rd);
            sb.mismatches++;
        end
    endtask

    task automatic pause_until_drained();
        item_ch.valid <= 1'b0;
        while (sb.pending_samples.size() != 0)
            @(posedge clk);
        // A trailing pixel write may still be in flight with nothing to wait for.
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic program_registers(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h,
                                     input logic [SCALE_BITS-1:0] hs,
                                     input logic [SCALE_BITS-1:0] vs, input logic mode);
        pause_until_drained();
        set_register(REG_SOURCE_WIDTH, PDATA_W'(w));
        set_register(REG_SOURCE_HEIGHT, PDATA_W'(h));
        set_register(REG_HORIZONTAL_SCALE, PDATA_W'(hs));
        set_register(REG_VERTICAL_SCALE, PDATA_W'(vs));
        set_register(REG_SAMPLING_MODE, PDATA_W'(mode));
        psel    <= 1'b0;
        penable <= 1'b0;
        settings++;
    endtask

    task automatic send_item(input logic kind, input int unsigned col, input int unsigned row,
                             input int unsigned ch, input int unsigned value);
        while (!steady && $urandom_range(99) < 30)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.kind          <= kind;
        item_ch.column        <= col[COL_BITS-1:0];
        item_ch.row           <= row[ROW_BITS-1:0];
        item_ch.channel_index <= ch[CH_BITS-1:0];
        item_ch.pixel_value   <= value[PIX_BITS-1:0];
        do @(posedge clk); while (item_ch.ready !== 1'b1);
        sb.note_item(kind, col, row, ch, value);
    endtask

    function automatic int unsigned random_pixel();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    // Fills every pixel the request will read that was never written, then requests it.
    task automatic sample_at(input int unsigned col, input int unsigned row,
                             input int unsigned ch);
        tap_q_t t;
        int unsigned idx;
        t = sb.taps(col, row, ch);
        foreach (t[k])
        begin
            idx = t[k];
            if (!sb.written[idx])
                send_item(KIND_WRITE, (idx / IRS_CHANNELS) % IRS_MAX_WIDTH,
                          idx / IRS_CHANNELS / IRS_MAX_WIDTH, idx % IRS_CHANNELS,
                          random_pixel());
        end
        send_item(KIND_REQUEST, col, row, ch, $urandom_range(255));
    endtask

    function automatic logic [SIZE_BITS-1:0] pick_size();
        case ($urandom_range(11))
            0:       return SIZE_BITS'(0);
            1:       return SIZE_BITS'(255);
            2:       return SIZE_BITS'(128);
            3:       return SIZE_BITS'(1);
            default: return SIZE_BITS'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [SCALE_BITS-1:0] pick_scale(logic [SIZE_BITS-1:0] src,
                                                         int unsigned dst);
        int unsigned s;
        case ($urandom_range(9))
            0:       return SCALE_BITS'(512);
            1:       return 24'h800000;
            2:       return SCALE_BITS'($urandom());
            default:
            begin
                s = ((src == 0 ? 1 : int'(src)) << FRAC_BITS) / dst;
                if (s < 512)
                    s = 512;
                return SCALE_BITS'(s);
            end
        endcase
    endfunction

    function automatic int unsigned pick_coord(int unsigned dst);
        if ($urandom_range(9) < 8)
            return $urandom_range(dst - 1);
        return $urandom_range(127);
    endfunction

    initial
    begin : result_receiver
        int hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= steady || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge clk)
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            sb.check_sample(result_ch.sample);

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
                || (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        logic [SIZE_BITS-1:0] w;
        logic [SIZE_BITS-1:0] h;
        logic                 mode;
        int unsigned          dst_w;
        int unsigned          dst_h;
        int unsigned          target;
        logic [PDATA_W-1:0]   rd;

        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        item_ch.valid         <= 1'b0;
        item_ch.kind          <= KIND_WRITE;
        item_ch.column        <= '0;
        item_ch.row           <= '0;
        item_ch.channel_index <= '0;
        item_ch.pixel_value   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: bilinear over a full 128x128 image at unit scale.
        send_item(KIND_WRITE, 0, 0, 0, 255);
        send_item(KIND_WRITE, 1, 0, 0, 0);
        send_item(KIND_WRITE, 0, 1, 0, 0);
        send_item(KIND_WRITE, 1, 1, 0, 255);
        sample_at(0, 0, 0);
        send_item(KIND_WRITE, 127, 127, BAD_CHANNEL, 255);
        send_item(KIND_REQUEST, 127, 127, BAD_CHANNEL, 255);
        send_item(KIND_WRITE, 127, 127, 2, 128);
        sample_at(127, 127, 2);

        // Largest and smallest scales in range; far positions clamp to the edges.
        program_registers(128, 128, 24'h800000, 512, MODE_BILINEAR);
        sample_at(127, 127, 2);
        sample_at(0, 0, 0);

        // Zero scale lands on -0.5 and rounds away from zero; bad sizes act as 1 and 128.
        program_registers(0, 255, 0, 0, MODE_NEAREST);
        sample_at(5, 9, 1);

        program_registers(1, 1, 24'hFFFFFF, 24'hFFFFFF, MODE_BILINEAR);
        sample_at(127, 127, 0);
        pause_until_drained();
        apb_transfer(1'b1, REG_UNUSED, '1, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        sample_at(0, 0, 0);

        // Scale 2.0 puts destination pixel 0 exactly halfway between sources.
        program_registers(4, 4, 24'h020000, 24'h020000, MODE_NEAREST);
        sample_at(0, 0, 0);
        sample_at(1, 0, 1);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            w     = pick_size();
            h     = pick_size();
            dst_w = $urandom_range(1, 128);
            dst_h = $urandom_range(1, 128);
            if (phase == 0)
                mode = MODE_NEAREST;
            else if (phase == 1)
                mode = MODE_BILINEAR;
            else
                mode = 1'($urandom_range(1));
            program_registers(w, h, pick_scale(w, dst_w), pick_scale(h, dst_h), mode);
            steady = (phase == STEADY_PHASE);
            if (phase == HOLD_PHASE)
                hold_request = 1'b1;
            target = sb.items + PHASE_ITEMS;
            while (sb.items < target)
            begin
                case ($urandom_range(19))
                    0, 1, 2:
                        send_item(KIND_WRITE, $urandom_range(127), $urandom_range(127),
                                  $urandom_range(3), random_pixel());
                    3:
                        send_item(KIND_REQUEST, $urandom_range(127), $urandom_range(127),
                                  BAD_CHANNEL, $urandom_range(255));
                    default:
                        sample_at(pick_coord(dst_w), pick_coord(dst_h), $urandom_range(2));
                endcase
            end
            steady = 1'b0;
        end

        pause_until_drained();
        $display("Covered %0d pixel writes and %0d requests (%0d bilinear, %0d nearest).",
                 sb.writes, sb.requests, sb.bilinear, sb.nearest);
        $display("Compared %0d samples over %0d register settings.", sb.checked, settings);
        if (sb.mismatches == 0 && sb.pending_samples.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

[filelist.f]
hdl/irs_pkg.sv
hdl/irs_if.sv
hdl/irs_pixel_store.sv
hdl/irs_coord_unit.sv
hdl/image_resize_sampler.sv
hdl/irs_checker.sv
dv/tb.sv
